>>> rtl/cdeq_pkg.sv
`timescale 1ns / 1ps

package cdeq_pkg;

    localparam int unsigned DEF_STORE_DEPTH   = 1024;
    localparam int unsigned DEF_ELEMENT_WIDTH = 32;

    localparam int unsigned KIND_W   = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CAP_W    = 11;
    localparam int unsigned CNT_W    = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [KIND_W-1:0] K_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] K_PUSH_REAR  = 3'd1;
    localparam logic [KIND_W-1:0] K_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] K_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] K_PEEK_FRONT = 3'd4;
    localparam logic [KIND_W-1:0] K_PEEK_REAR  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Response bookkeeping from the controller, aligned with the store read data.
    typedef struct packed {
        logic                strobe;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
        logic                elem_en;
    } t_rsp;

endpackage

>>> rtl/cdeq_store.sv
`timescale 1ns / 1ps

module cdeq_store #(
    parameter int unsigned STORE_DEPTH   = cdeq_pkg::DEF_STORE_DEPTH,
    parameter int unsigned ELEMENT_WIDTH = cdeq_pkg::DEF_ELEMENT_WIDTH,
    localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_addr,
    input  logic [ELEMENT_WIDTH-1:0] i_wdata,
    output logic [ELEMENT_WIDTH-1:0] o_rdata
);
    import cdeq_pkg::*;

    logic [ELEMENT_WIDTH-1:0] r_mem [STORE_DEPTH];
    logic [ELEMENT_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cdeq_ctrl.sv
`timescale 1ns / 1ps

module cdeq_ctrl #(
    parameter int unsigned STORE_DEPTH = cdeq_pkg::DEF_STORE_DEPTH,
    localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [cdeq_pkg::KIND_W-1:0]   i_kind,
    input  logic                          i_cfg_we,
    input  logic [cdeq_pkg::CAP_W-1:0]    i_cfg_data,
    output logic                          o_we,
    output logic                          o_re,
    output logic [AW-1:0]                 o_addr,
    output cdeq_pkg::t_rsp                o_rsp
);
    import cdeq_pkg::*;

    // Index arithmetic width: wide enough for an index plus one and for the capacity.
    localparam int unsigned IW = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;
    localparam int unsigned DEPTH_SAT = (STORE_DEPTH > 2047) ? 2047 : STORE_DEPTH;

    logic [CAP_W-1:0] r_cap;
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    r_tail;
    logic [CNT_W-1:0] r_count;
    t_rsp             r_rsp;

    logic [AW-1:0]    n_head;
    logic [AW-1:0]    n_tail;
    logic [CNT_W-1:0] n_count;
    t_rsp             n_rsp;

    logic [CAP_W-1:0] cap_eff;
    logic [IW-1:0]    cap_wide;
    logic [AW-1:0]    cap_last;
    logic [AW-1:0]    head_fwd;
    logic [AW-1:0]    head_back;
    logic [AW-1:0]    tail_fwd;
    logic [AW-1:0]    tail_back;
    logic             is_empty;
    logic             is_full;

    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CAP_W'(1);
        end else if (r_cap > CAP_W'(DEPTH_SAT)) begin
            cap_eff = CAP_W'(DEPTH_SAT);
        end else begin
            cap_eff = r_cap;
        end
    end

    assign cap_wide = IW'(cap_eff);
    assign cap_last = AW'(cap_wide - IW'(1));

    // A forward step from the last usable entry, or beyond it, wraps to zero.
    assign head_fwd  = ((IW'(r_head) + IW'(1)) >= cap_wide) ? '0 : AW'(r_head + AW'(1));
    assign tail_fwd  = ((IW'(r_tail) + IW'(1)) >= cap_wide) ? '0 : AW'(r_tail + AW'(1));
    assign head_back = (r_head == '0) ? cap_last : AW'(r_head - AW'(1));
    assign tail_back = (r_tail == '0) ? cap_last : AW'(r_tail - AW'(1));

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count >= cap_eff);

    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        o_we          = 1'b0;
        o_re          = 1'b0;
        o_addr        = r_head;
        n_rsp.strobe  = i_accept;
        n_rsp.status  = ST_OK;
        n_rsp.elem_en = 1'b0;

        if (i_accept) begin
            case (i_kind)
                K_PUSH_FRONT, K_PUSH_REAR: begin
                    if (is_full) begin
                        n_rsp.status = ST_FULL;
                    end else if (is_empty) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = CNT_W'(1);
                        o_we    = 1'b1;
                        o_addr  = '0;
                    end else if (i_kind == K_PUSH_FRONT) begin
                        n_head  = head_back;
                        n_count = r_count + CNT_W'(1);
                        o_we    = 1'b1;
                        o_addr  = head_back;
                    end else begin
                        n_tail  = tail_fwd;
                        n_count = r_count + CNT_W'(1);
                        o_we    = 1'b1;
                        o_addr  = tail_fwd;
                    end
                end
                K_POP_FRONT, K_POP_REAR: begin
                    if (is_empty) begin
                        n_rsp.status = ST_EMPTY;
                    end else if (i_kind == K_POP_FRONT) begin
                        o_re    = 1'b1;
                        o_addr  = r_head;
                        n_head  = head_fwd;
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        o_re    = 1'b1;
                        o_addr  = r_tail;
                        n_tail  = tail_back;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                K_PEEK_FRONT, K_PEEK_REAR: begin
                    if (is_empty) begin
                        n_rsp.status = ST_EMPTY;
                    end else begin
                        o_re   = 1'b1;
                        o_addr = (i_kind == K_PEEK_FRONT) ? r_head : r_tail;
                    end
                end
                default: begin
                end
            endcase
        end

        n_rsp.count   = n_count;
        n_rsp.elem_en = o_re;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_rsp   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_rsp   <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

>>> rtl/circular_double_ended_queue_top.sv
`timescale 1ns / 1ps

// Double-ended queue held in a single-port synchronous store. A request is taken
// at any clock edge where start is high; busy stays low, so one request per cycle
// is accepted. Each request touches at most one store entry, and its result
// (status, popped or peeked element, element count) appears on the result ports
// for exactly one cycle, marked by o_done, in the cycle after acceptance, since
// the store registers its read data. The receiver cannot stall results:
// it must take each one in the cycle it is shown. The capacity register is
// always ready and should be written only while no request is in flight.
module circular_double_ended_queue_top #(
    parameter int unsigned STORE_DEPTH   = cdeq_pkg::DEF_STORE_DEPTH,
    parameter int unsigned ELEMENT_WIDTH = cdeq_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cdeq_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [ELEMENT_WIDTH-1:0]     i_push_value,
    output logic                                o_done,
    output logic [cdeq_pkg::STATUS_W-1:0]       o_status,
    output logic signed [ELEMENT_WIDTH-1:0]     o_element_out,
    output logic [cdeq_pkg::CNT_W-1:0]          o_element_count,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cdeq_pkg::CAP_W-1:0]          i_cfg_data
);
    import cdeq_pkg::*;

    localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic                     accept;
    logic                     mem_we;
    logic                     mem_re;
    logic [AW-1:0]            mem_addr;
    logic [ELEMENT_WIDTH-1:0] mem_rdata;
    t_rsp                     rsp;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start & ~busy;

    cdeq_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_kind     (i_kind),
        .i_cfg_we   (i_cfg_valid & o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_we       (mem_we),
        .o_re       (mem_re),
        .o_addr     (mem_addr),
        .o_rsp      (rsp)
    );

    cdeq_store #(
        .STORE_DEPTH   (STORE_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (i_push_value),
        .o_rdata (mem_rdata)
    );

    assign o_done          = rsp.strobe;
    assign o_status        = rsp.status;
    assign o_element_count = rsp.count;
    // Only pops and peeks that found an element return store data.
    assign o_element_out   = rsp.elem_en ? mem_rdata : '0;

endmodule

>>> tb/circular_double_ended_queue_top_test.sv
`timescale 1ns / 1ps

module circular_double_ended_queue_top_test;

    import cdeq_pkg::*;

    localparam int unsigned STORE_DEPTH   = DEF_STORE_DEPTH;
    localparam int unsigned ELEMENT_WIDTH = DEF_ELEMENT_WIDTH;
    localparam int unsigned CYCLE_LIMIT   = 100000;

    // Kinds 6 and 7 carry no operation; the block answers them with the current count.
    localparam logic [KIND_W-1:0] K_RESERVED_LO = 3'd6;
    localparam logic [KIND_W-1:0] K_RESERVED_HI = 3'd7;

    // Two copies of the deque state: one follows the accepted requests and
    // predicts results, the other runs ahead while requests are planned.
    localparam int MODEL_LIVE = 0;
    localparam int MODEL_PLAN = 1;

    typedef struct {
        logic [KIND_W-1:0]               kind;
        logic signed [ELEMENT_WIDTH-1:0] value;
    } deque_request_t;

    typedef struct {
        logic [STATUS_W-1:0]             status;
        logic signed [ELEMENT_WIDTH-1:0] element;
        logic [CNT_W-1:0]                count;
    } deque_result_t;

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            start           = 1'b0;
    logic                            busy;
    logic [KIND_W-1:0]               i_kind          = '0;
    logic signed [ELEMENT_WIDTH-1:0] i_push_value    = '0;
    logic                            o_done;
    logic [STATUS_W-1:0]             o_status;
    logic signed [ELEMENT_WIDTH-1:0] o_element_out;
    logic [CNT_W-1:0]                o_element_count;
    logic                            i_cfg_valid     = 1'b0;
    logic                            o_cfg_ready;
    logic [CAP_W-1:0]                i_cfg_data      = '0;

    logic signed [ELEMENT_WIDTH-1:0] slot_data    [2][STORE_DEPTH];
    bit                              slot_written [2][STORE_DEPTH];
    int unsigned                     head_at [2] = '{0, 0};
    int unsigned                     tail_at [2] = '{0, 0};
    int unsigned                     held    [2] = '{0, 0};
    int unsigned                     cap_reg [2] = '{CAP_RESET, CAP_RESET};

    deque_request_t request_q [$];
    deque_result_t  result_q  [$];
    int unsigned    planned_total  = 0;
    int unsigned    accepted_total = 0;
    int unsigned    error_count    = 0;
    int unsigned    cycle_count    = 0;
    bit             steady         = 1'b0;

    circular_double_ended_queue_top #(
        .STORE_DEPTH   (STORE_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_push_value    (i_push_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_element_out   (o_element_out),
        .o_element_count (o_element_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void store_put(input int m, input int unsigned idx,
                                      input logic signed [ELEMENT_WIDTH-1:0] value);
        slot_data[m][idx]    = value;
        slot_written[m][idx] = 1'b1;
    endfunction

    function automatic void deque_step(input int m, input logic [KIND_W-1:0] kind,
                                       input logic signed [ELEMENT_WIDTH-1:0] value,
                                       output deque_result_t res);
        int unsigned cap;
        cap = cap_reg[m];
        if (cap == 0) cap = 1;
        if (cap > STORE_DEPTH) cap = STORE_DEPTH;
        res.status  = ST_OK;
        res.element = '0;
        case (kind)
            K_PUSH_FRONT, K_PUSH_REAR: begin
                if (held[m] >= cap) begin
                    res.status = ST_FULL;
                end else if (held[m] == 0) begin
                    head_at[m] = 0;
                    tail_at[m] = 0;
                    store_put(m, 0, value);
                    held[m] = 1;
                end else if (kind == K_PUSH_FRONT) begin
                    head_at[m] = (head_at[m] == 0) ? cap - 1 : head_at[m] - 1;
                    store_put(m, head_at[m], value);
                    held[m]++;
                end else begin
                    tail_at[m] = (tail_at[m] + 1 >= cap) ? 0 : tail_at[m] + 1;
                    store_put(m, tail_at[m], value);
                    held[m]++;
                end
            end
            K_POP_FRONT, K_POP_REAR: begin
                if (held[m] == 0) begin
                    res.status = ST_EMPTY;
                end else if (kind == K_POP_FRONT) begin
                    res.element = slot_data[m][head_at[m]];
                    head_at[m]  = (head_at[m] + 1 >= cap) ? 0 : head_at[m] + 1;
                    held[m]--;
                end else begin
                    res.element = slot_data[m][tail_at[m]];
                    tail_at[m]  = (tail_at[m] == 0) ? cap - 1 : tail_at[m] - 1;
                    held[m]--;
                end
            end
            K_PEEK_FRONT, K_PEEK_REAR: begin
                if (held[m] == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.element = slot_data[m][(kind == K_PEEK_FRONT) ? head_at[m] : tail_at[m]];
                end
            end
            default: ;
        endcase
        res.count = CNT_W'(held[m]);
    endfunction

    function automatic void plan_request(input logic [KIND_W-1:0] kind,
                                         input logic signed [ELEMENT_WIDTH-1:0] value);
        deque_request_t req;
        deque_result_t  shadow_result;
        int unsigned    idx;
        if (held[MODEL_PLAN] != 0 &&
            kind inside {K_POP_FRONT, K_POP_REAR, K_PEEK_FRONT, K_PEEK_REAR}) begin
            idx = (kind == K_POP_FRONT || kind == K_PEEK_FRONT) ?
                  head_at[MODEL_PLAN] : tail_at[MODEL_PLAN];
            // After a capacity change a pointer can land on a slot that was never
            // written; reading it is not allowed, so a push goes in its place.
            if (!slot_written[MODEL_PLAN][idx]) kind = K_PUSH_REAR;
        end
        deque_step(MODEL_PLAN, kind, value, shadow_result);
        req.kind  = kind;
        req.value = value;
        request_q.push_back(req);
        planned_total++;
    endfunction

    task automatic wait_drained();
        while (accepted_total != planned_total || result_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] capacity, input int unsigned n_requests,
                             input int unsigned push_pct, input bit no_gaps);
        logic [KIND_W-1:0]               kind;
        logic signed [ELEMENT_WIDTH-1:0] value;
        int unsigned                     i;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= capacity;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        cap_reg[MODEL_LIVE] = capacity;
        cap_reg[MODEL_PLAN] = capacity;
        steady = no_gaps;
        for (i = 0; i < n_requests; i++) begin
            if ($urandom_range(99) < push_pct) begin
                kind = $urandom_range(1) ? K_PUSH_REAR : K_PUSH_FRONT;
            end else begin
                case ($urandom_range(9))
                    0, 1:    kind = K_POP_FRONT;
                    2, 3:    kind = K_POP_REAR;
                    4, 5:    kind = K_PEEK_FRONT;
                    6, 7:    kind = K_PEEK_REAR;
                    8:       kind = K_RESERVED_LO;
                    default: kind = K_RESERVED_HI;
                endcase
            end
            if ($urandom_range(15) == 0) begin
                case ($urandom_range(3))
                    0:       value = 32'sh8000_0000;
                    1:       value = 32'sh7FFF_FFFF;
                    2:       value = '0;
                    default: value = '1;
                endcase
            end else begin
                value = $urandom();
            end
            plan_request(kind, value);
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin : request_driver
        deque_request_t next_req;
        deque_result_t  outcome;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                deque_step(MODEL_LIVE, i_kind, i_push_value, outcome);
                result_q.push_back(outcome);
                accepted_total++;
            end
            if (!start || !busy) begin
                if (request_q.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
                    next_req = request_q.pop_front();
                    start        <= 1'b1;
                    i_kind       <= next_req.kind;
                    i_push_value <= next_req.value;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        deque_result_t want;
        if (o_done === 1'b1) begin
            if (result_q.size() == 0) begin
                $error("result shown with no request outstanding");
                error_count++;
            end else begin
                want = result_q.pop_front();
                if (o_status !== want.status) begin
                    $error("o_status mismatch: expected %0d, actual %0d", want.status, o_status);
                    error_count++;
                end
                if (o_element_out !== want.element) begin
                    $error("o_element_out mismatch: expected %0d, actual %0d",
                           want.element, o_element_out);
                    error_count++;
                end
                if (o_element_count !== want.count) begin
                    $error("o_element_count mismatch: expected %0d, actual %0d",
                           want.count, o_element_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue at full capacity: every read fails, spare kinds report zero.
        plan_request(K_POP_FRONT, $urandom());
        plan_request(K_POP_REAR, $urandom());
        plan_request(K_PEEK_FRONT, $urandom());
        plan_request(K_PEEK_REAR, $urandom());
        plan_request(K_RESERVED_LO, $urandom());
        plan_request(K_RESERVED_HI, $urandom());
        // The first push lands in slot zero; a front push then wraps to the top slot.
        plan_request(K_PUSH_FRONT, 32'sh8000_0000);
        plan_request(K_PUSH_REAR, 32'sh7FFF_FFFF);
        plan_request(K_PUSH_FRONT, '1);
        plan_request(K_PUSH_REAR, '0);
        plan_request(K_PEEK_FRONT, $urandom());
        plan_request(K_PEEK_REAR, $urandom());
        plan_request(K_RESERVED_LO, $urandom());
        plan_request(K_POP_FRONT, $urandom());
        plan_request(K_POP_REAR, $urandom());
        plan_request(K_POP_FRONT, $urandom());
        plan_request(K_POP_REAR, $urandom());
        plan_request(K_POP_FRONT, $urandom());
        plan_request(K_PUSH_REAR, 32'sh5555_5555);
        plan_request(K_PUSH_FRONT, 32'shAAAA_AAAA);
        plan_request(K_PEEK_REAR, $urandom());
        plan_request(K_POP_REAR, $urandom());
        plan_request(K_POP_FRONT, $urandom());
        wait_drained();

        run_phase(11'd1, 15, 50, 1'b0);
        run_phase(11'd0, 10, 50, 1'b0);
        run_phase(11'd2, 15, 50, 1'b0);
        run_phase(11'd3, 20, 45, 1'b1);
        run_phase(11'd9, 20, 55, 1'b0);
        // Fill to the top of the store so that the full case is hit at the largest size.
        run_phase(11'd2047, 1028, 100, 1'b0);
        run_phase(11'd1025, 10, 60, 1'b0);
        // Shrink the capacity while the store is crowded; the pointers wrap early.
        run_phase(11'd6, 20, 35, 1'b0);
        run_phase(11'd1024, 10, 50, 1'b0);

        repeat (5) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/cdeq_pkg.sv
rtl/cdeq_store.sv
rtl/cdeq_ctrl.sv
rtl/circular_double_ended_queue_top.sv
tb/circular_double_ended_queue_top_test.sv
